// ----- src/bpbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary / packed BCD converter package
// Field widths, request codes, control bundle and division constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bpbc_pkg;

	localparam int BIN_W = 32;
	localparam int BCD_W = 32;
	localparam int RES_W = 28;
	localparam int CNT_W = 3;
	localparam int MAX_BYTES = 4;

	// request codes
	localparam logic REQ_TO_BCD = 1'b0;
	localparam logic REQ_TO_BIN = 1'b1;

	// largest value that fits in 1..4 BCD bytes
	localparam logic [BIN_W-1:0] LIMIT_TAB [MAX_BYTES] = '{
		32'd99, 32'd9999, 32'd999999, 32'd99999999
	};

	// exact reciprocals: floor(x / D) == (x * M) >> S over the value range used
	localparam logic [27:0] RECIP_10K   = 28'd219902326;  // x < 2^27, shift 41
	localparam int          SHIFT_10K   = 41;
	localparam logic [14:0] RECIP_100   = 15'd20972;      // x < 2^14, shift 21
	localparam int          SHIFT_100   = 21;

	typedef struct packed {
		logic             req;
		logic [CNT_W-1:0] cnt;   // clamped to 1..4
		logic             rev;
		logic             ovf;
	} ctl_t;

endpackage

`default_nettype wire

// ----- src/bpbc_if.sv -----
// ----------------------------------------------------------------------------
// Converter channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpbc_in_if import bpbc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [CNT_W-1:0] byte_count;
	logic             byte_order;
	logic [BIN_W-1:0] bin_value;
	logic [BCD_W-1:0] bcd_value;

	modport source (output valid, req_type, byte_count, byte_order, bin_value, bcd_value,
		input ready);
	modport sink (input valid, req_type, byte_count, byte_order, bin_value, bcd_value,
		output ready);
endinterface

interface bpbc_out_if import bpbc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BCD_W-1:0] bcd_result;
	logic [RES_W-1:0] bin_result;
	logic             overflow;

	modport source (output valid, bcd_result, bin_result, overflow, input ready);
	modport sink (input valid, bcd_result, bin_result, overflow, output ready);
endinterface

`default_nettype wire

// ----- src/binary_packed_bcd_converter.sv -----
// ----------------------------------------------------------------------------
// Binary / packed BCD converter
// Five-stage pipeline converting binary <-> packed BCD of 1 to 4 bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+----------------------------------------------------------
//  din     | in  | req_type, byte_count, byte_order, bin_value, bcd_value
//  dout    | out | bcd_result, bin_result, overflow
//
//  Five register stages, s1 to s5, hold each item from acceptance to the
//  output; one item per cycle unless dout stalls the output stage.
//  The stage count is set by the reciprocal multiplies (divide by 10000,
//  then by 100) and the remainder multiplies that follow each of them.
//  Each stage advances when it is empty or the stage after it moves, so
//  bubbles close up under a stall. arst_n clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_packed_bcd_converter import bpbc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	bpbc_in_if.sink   din,
	bpbc_out_if.source dout
);

	function automatic logic [7:0] bcd_to_byte(input logic [7:0] b);
		return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
	endfunction

	function automatic logic [7:0] pair_to_bcd(input logic [6:0] p);
		logic [14:0] m;
		logic [3:0]  tens;
		logic [6:0]  ones;
		m    = 15'(p) * 15'd205;   // floor(p/10) for p < 100
		tens = m[14:11];
		ones = p - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	// ---------------- handshake ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !valid_s5 || dout.ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign din.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= din.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// ---------------- stage 1: clamp, range check, /10000, byte weights ----------
	ctl_t             ctl_c;
	logic [54:0]      prod_10k;
	logic [7:0]       bval [MAX_BYTES];
	logic [7:0]       w_c  [MAX_BYTES];
	logic             div_off;

	always_comb begin
		logic [CNT_W-1:0] idx3;
		case (din.byte_count)
			3'd0:                      ctl_c.cnt = 3'd1;
			3'd1, 3'd2, 3'd3, 3'd4:    ctl_c.cnt = din.byte_count;
			default:                   ctl_c.cnt = 3'(MAX_BYTES);
		endcase
		ctl_c.req = din.req_type;
		ctl_c.rev = din.byte_order;
		ctl_c.ovf = (din.req_type == REQ_TO_BCD) &&
			(din.bin_value > LIMIT_TAB[2'(ctl_c.cnt - 3'd1)]);
		prod_10k = 55'(din.bin_value[26:0]) * 55'(RECIP_10K);
		for (int j = 0; j < MAX_BYTES; j++) begin
			bval[j] = bcd_to_byte(din.bcd_value[8*j +: 8]);
		end
		for (int j = 0; j < MAX_BYTES; j++) begin
			idx3   = ctl_c.rev ? (ctl_c.cnt - 3'd1 - 3'(j)) : 3'(j);
			w_c[j] = (3'(j) < ctl_c.cnt) ? bval[idx3[1:0]] : 8'd0;
		end
	end

	// digit path only carries in-range binary requests
	assign div_off = ctl_c.ovf || (ctl_c.req == REQ_TO_BIN);

	ctl_t        ctl_s1;
	logic [13:0] qhi_s1;
	logic [26:0] v_s1;
	logic [7:0]  w_s1 [MAX_BYTES];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ctl_s1 <= ctl_c;
			qhi_s1 <= div_off ? 14'd0 : prod_10k[SHIFT_10K +: 14];
			v_s1   <= div_off ? 27'd0 : din.bin_value[26:0];
			w_s1   <= w_c;
		end
	end

	// ---------------- stage 2: low remainder, pair sums ----------------
	logic [26:0] rem_10k;
	assign rem_10k = v_s1 - 27'(qhi_s1) * 27'd10000;

	ctl_t        ctl_s2;
	logic [13:0] qhi_s2, rlo_s2;
	logic [14:0] lo_s2, hi_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			ctl_s2 <= ctl_s1;
			qhi_s2 <= qhi_s1;
			rlo_s2 <= rem_10k[13:0];
			lo_s2  <= 15'(w_s1[0]) + 15'(w_s1[1]) * 15'd100;
			hi_s2  <= 15'(w_s1[2]) + 15'(w_s1[3]) * 15'd100;
		end
	end

	// ---------------- stage 3: /100 of both halves, binary total ----------------
	logic [28:0] prod_hi, prod_lo;
	assign prod_hi = 29'(qhi_s2) * 29'(RECIP_100);
	assign prod_lo = 29'(rlo_s2) * 29'(RECIP_100);

	ctl_t             ctl_s3;
	logic [13:0]      qhi_s3, rlo_s3;
	logic [6:0]       thi_s3, tlo_s3;
	logic [RES_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			ctl_s3 <= ctl_s2;
			qhi_s3 <= qhi_s2;
			rlo_s3 <= rlo_s2;
			thi_s3 <= prod_hi[SHIFT_100 +: 7];
			tlo_s3 <= prod_lo[SHIFT_100 +: 7];
			sum_s3 <= 28'(lo_s2) + 28'(hi_s2) * 28'd10000;
		end
	end

	// ---------------- stage 4: digit pairs ----------------
	logic [13:0] r_hi, r_lo;
	assign r_hi = qhi_s3 - 14'(thi_s3) * 14'd100;
	assign r_lo = rlo_s3 - 14'(tlo_s3) * 14'd100;

	ctl_t             ctl_s4;
	logic [6:0]       pair_s4 [MAX_BYTES];   // lowest pair first
	logic [RES_W-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			ctl_s4     <= ctl_s3;
			pair_s4[0] <= r_lo[6:0];
			pair_s4[1] <= tlo_s3;
			pair_s4[2] <= r_hi[6:0];
			pair_s4[3] <= thi_s3;
			sum_s4     <= sum_s3;
		end
	end

	// ---------------- stage 5: BCD encode, byte order, output register ----------
	logic [BCD_W-1:0] bcd_c;

	always_comb begin
		logic [CNT_W-1:0] idx3;
		for (int j = 0; j < MAX_BYTES; j++) begin
			idx3 = ctl_s4.rev ? (ctl_s4.cnt - 3'd1 - 3'(j)) : 3'(j);
			bcd_c[8*j +: 8] = (3'(j) < ctl_s4.cnt) ? pair_to_bcd(pair_s4[idx3[1:0]]) : 8'd0;
		end
	end

	logic [BCD_W-1:0] bcd_result_s5;
	logic [RES_W-1:0] bin_result_s5;
	logic             ovf_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			bcd_result_s5 <= (ctl_s4.req == REQ_TO_BCD && !ctl_s4.ovf) ? bcd_c : '0;
			bin_result_s5 <= (ctl_s4.req == REQ_TO_BIN) ? sum_s4 : '0;
			ovf_s5        <= (ctl_s4.req == REQ_TO_BCD) && ctl_s4.ovf;
		end
	end

	assign dout.valid      = valid_s5;
	assign dout.bcd_result = bcd_result_s5;
	assign dout.bin_result = bin_result_s5;
	assign dout.overflow   = ovf_s5;

	// ---------------- assertions ----------------
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.overflow |-> dout.bcd_result == '0)
		else $error("overflow with nonzero BCD");

	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.bin_result != '0 |-> dout.bcd_result == '0 && !dout.overflow)
		else $error("both directions produced a result");

	a_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> pair_s4[0] < 7'd100 && pair_s4[1] < 7'd100 &&
			pair_s4[2] < 7'd100 && pair_s4[3] < 7'd100)
		else $error("digit pair out of range");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> valid_s1)
		else $error("accepted item lost at stage 1");

endmodule

`default_nettype wire

// ----- tb/bpbc_checker.sv -----
// ----------------------------------------------------------------------------
// Binary / packed BCD converter checker
// Watches both channels, predicts each result from the accepted item and
// compares it field by field with what the converter hands out.
// ----------------------------------------------------------------------------
module bpbc_checker import bpbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bpbc_in_if   din,
	bpbc_out_if  dout,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [RES_W-1:0] bin;
		logic             ovf;
	} conversion_t;

	conversion_t expected_q[$];
	int          error_count = 0;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic conversion_t convert_item(input logic req,
			input logic [CNT_W-1:0] cnt_raw, input logic rev,
			input logic [BIN_W-1:0] bin, input logic [BCD_W-1:0] bcd);
		int unsigned      n;
		int unsigned      pos;
		longint unsigned  ceiling;
		longint unsigned  scale;
		longint unsigned  total;
		logic [BIN_W-1:0] rest;
		logic [BCD_W-1:0] packed_bcd;
		logic [7:0]       pair;
		conversion_t      res;
		// out-of-range counts fold onto 1 or 4 bytes
		n = (cnt_raw == 0) ? 1 : ((cnt_raw > MAX_BYTES) ? MAX_BYTES : cnt_raw);
		res = '0;
		packed_bcd = '0;
		total = 0;
		ceiling = 1;
		for (int k = 0; k < n; k++)
			ceiling *= 100;
		if (req == REQ_TO_BCD) begin
			if (bin > ceiling - 1) begin
				res.ovf = 1'b1;
			end else begin
				rest = bin;
				for (int k = 0; k < n; k++) begin
					pos = rev ? (n - 1 - k) : k;
					pair = {4'((rest % 100) / 10), 4'(rest % 10)};
					packed_bcd[8*pos +: 8] = pair;
					rest = rest / 100;
				end
				res.bcd = packed_bcd;
			end
		end else begin
			// no digit check: a nibble above nine still weighs in
			for (int k = 0; k < n; k++) begin
				pair = bcd[8*k +: 8];
				pos = rev ? (n - 1 - k) : k;
				scale = 1;
				repeat (pos) scale *= 100;
				total += (pair[7:4] * 10 + pair[3:0]) * scale;
			end
			res.bin = total[RES_W-1:0];
		end
		return res;
	endfunction

	always @(posedge clk) begin
		conversion_t exp_item;
		if (arst_n) begin
			if (dout.valid && dout.ready) begin
				if (expected_q.size() == 0) begin
					report($sformatf("result with nothing expected: bcd %h bin %0d ovf %b",
						dout.bcd_result, dout.bin_result, dout.overflow));
				end else begin
					exp_item = expected_q.pop_front();
					if (dout.bcd_result !== exp_item.bcd)
						report($sformatf("bcd_result got %h exp %h",
							dout.bcd_result, exp_item.bcd));
					if (dout.bin_result !== exp_item.bin)
						report($sformatf("bin_result got %0d exp %0d",
							dout.bin_result, exp_item.bin));
					if (dout.overflow !== exp_item.ovf)
						report($sformatf("overflow got %b exp %b",
							dout.overflow, exp_item.ovf));
				end
			end
			if (din.valid && din.ready)
				expected_q.push_back(convert_item(din.req_type, din.byte_count,
					din.byte_order, din.bin_value, din.bcd_value));
		end
		pending <= expected_q.size();
		errors <= error_count;
	end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Binary / packed BCD converter testbench
// Directed corner items then random conversions in both directions, with
// random gaps on the input, random and long stalls on the output.
// ----------------------------------------------------------------------------
module testbench import bpbc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic ORDER_LOW_FIRST  = 1'b0;
	localparam logic ORDER_HIGH_FIRST = 1'b1;
	localparam int   RANDOM_ITEMS     = 930;
	localparam int   HOLD_AT_RESULT   = 300;
	localparam int   HOLD_CYCLES      = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   pending;
	int   send_calm = 0;
	int   recv_calm = 0;

	bpbc_in_if  din_ch();
	bpbc_out_if dout_ch();

	binary_packed_bcd_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	bpbc_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din_ch),
		.dout    (dout_ch),
		.errors  (errors),
		.pending (pending)
	);

	always #6 clk = ~clk;

	task automatic send_item(input logic req, input logic [CNT_W-1:0] cnt,
			input logic order, input logic [BIN_W-1:0] bin, input logic [BCD_W-1:0] bcd);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else if ($urandom_range(0, 24) == 0) begin
			gap = 0;
			send_calm = 40;
		end else begin
			gap = $urandom_range(0, 5);
		end
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.req_type <= req;
		din_ch.byte_count <= cnt;
		din_ch.byte_order <= order;
		din_ch.bin_value <= bin;
		din_ch.bcd_value <= bcd;
		do @(posedge clk); while (!din_ch.ready);
	endtask

	// result side: random stalls, calm stretches, one long hold-off
	initial begin
		int stall;
		int taken;
		taken = 0;
		dout_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == HOLD_AT_RESULT) begin
				stall = HOLD_CYCLES;
			end else if (recv_calm > 0) begin
				stall = 0;
				recv_calm--;
			end else if ($urandom_range(0, 24) == 0) begin
				stall = 0;
				recv_calm = 40;
			end else begin
				stall = $urandom_range(0, 5);
			end
			if (stall > 0) begin
				dout_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_ch.ready <= 1'b1;
			do @(posedge clk); while (!dout_ch.valid);
			taken++;
		end
	end

	initial begin
		#2_000_000;
		$display("[binary_packed_bcd_converter] ERROR");
		$finish;
	end

	initial begin
		logic [CNT_W-1:0] cnt;
		logic [BIN_W-1:0] limit;
		logic [BIN_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
		int               n;
		int               sel;
		din_ch.valid <= 1'b0;
		din_ch.req_type <= REQ_TO_BCD;
		din_ch.byte_count <= '0;
		din_ch.byte_order <= ORDER_LOW_FIRST;
		din_ch.bin_value <= '0;
		din_ch.bcd_value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// binary to BCD corners
		send_item(REQ_TO_BCD, 3'd1, ORDER_LOW_FIRST, 32'd0, $urandom());
		send_item(REQ_TO_BCD, 3'd1, ORDER_LOW_FIRST, 32'd99, $urandom());
		send_item(REQ_TO_BCD, 3'd1, ORDER_HIGH_FIRST, 32'd100, $urandom());
		send_item(REQ_TO_BCD, 3'd2, ORDER_HIGH_FIRST, 32'd9999, $urandom());
		send_item(REQ_TO_BCD, 3'd2, ORDER_LOW_FIRST, 32'd10000, $urandom());
		send_item(REQ_TO_BCD, 3'd3, ORDER_HIGH_FIRST, 32'd999999, $urandom());
		send_item(REQ_TO_BCD, 3'd3, ORDER_LOW_FIRST, 32'd1000000, $urandom());
		send_item(REQ_TO_BCD, 3'd4, ORDER_HIGH_FIRST, 32'd12345678, $urandom());
		send_item(REQ_TO_BCD, 3'd4, ORDER_LOW_FIRST, 32'd99999999, $urandom());
		send_item(REQ_TO_BCD, 3'd4, ORDER_LOW_FIRST, 32'd100000000, $urandom());
		send_item(REQ_TO_BCD, 3'd4, ORDER_HIGH_FIRST, 32'hFFFF_FFFF, $urandom());
		// count zero folds to one byte, above four to four bytes
		send_item(REQ_TO_BCD, 3'd0, ORDER_LOW_FIRST, 32'd42, $urandom());
		send_item(REQ_TO_BCD, 3'd7, ORDER_HIGH_FIRST, 32'd87654321, $urandom());
		send_item(REQ_TO_BCD, 3'd5, ORDER_LOW_FIRST, 32'd100000000, $urandom());
		// BCD to binary corners, incl. nibbles above nine and ignored upper bytes
		send_item(REQ_TO_BIN, 3'd1, ORDER_LOW_FIRST, $urandom(), 32'h0000_0000);
		send_item(REQ_TO_BIN, 3'd4, ORDER_LOW_FIRST, $urandom(), 32'h9999_9999);
		send_item(REQ_TO_BIN, 3'd4, ORDER_HIGH_FIRST, $urandom(), 32'h1234_5678);
		send_item(REQ_TO_BIN, 3'd4, ORDER_LOW_FIRST, $urandom(), 32'hFFFF_FFFF);
		send_item(REQ_TO_BIN, 3'd1, ORDER_HIGH_FIRST, $urandom(), 32'hFFFF_FF99);
		send_item(REQ_TO_BIN, 3'd2, ORDER_HIGH_FIRST, $urandom(), 32'h0000_1234);
		send_item(REQ_TO_BIN, 3'd0, ORDER_LOW_FIRST, $urandom(), 32'hABCD_EF56);
		send_item(REQ_TO_BIN, 3'd6, ORDER_HIGH_FIRST, $urandom(), 32'hFFFF_FFFF);
		send_item(REQ_TO_BIN, 3'd3, ORDER_LOW_FIRST, $urandom(), 32'hABCD_EF12);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 6) == 0)
				cnt = 3'($urandom_range(0, 7));
			else
				cnt = 3'($urandom_range(1, MAX_BYTES));
			n = (cnt == 0) ? 1 : ((cnt > MAX_BYTES) ? MAX_BYTES : cnt);
			limit = LIMIT_TAB[n-1];
			sel = $urandom_range(0, 9);
			if (sel < 6)
				bin = $urandom_range(0, limit);
			else if (sel == 6)
				bin = limit;
			else if (sel == 7)
				bin = limit + 1;
			else
				bin = $urandom();
			if ($urandom_range(0, 9) < 7) begin
				for (int d = 0; d < 8; d++)
					bcd[4*d +: 4] = 4'($urandom_range(0, 9));
			end else begin
				bcd = $urandom();
			end
			send_item($urandom_range(0, 1) ? REQ_TO_BIN : REQ_TO_BCD, cnt,
				$urandom_range(0, 1) ? ORDER_HIGH_FIRST : ORDER_LOW_FIRST, bin, bcd);
		end
		din_ch.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("[binary_packed_bcd_converter] OK");
		else
			$display("[binary_packed_bcd_converter] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/bpbc_pkg.sv
src/bpbc_if.sv
src/binary_packed_bcd_converter.sv
tb/bpbc_checker.sv
tb/testbench.sv
